/* hw/rtl/vcpt_pkg.sv */
`timescale 1ns / 1ps

package vcpt_pkg;

    // Fixed field widths
    localparam int SPAN_BITS      = 15;
    localparam int COORD_BITS_DEF = 16;
    localparam int OFF_BITS       = SPAN_BITS + 2;
    localparam int CFG_IDX_BITS   = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_APEX_X     = 3'd0,
        CFG_APEX_Y     = 3'd1,
        CFG_FACING     = 3'd2,
        CFG_REACH      = 3'd3,
        CFG_HALF_WIDTH = 3'd4
    } t_cfg_idx;

    // View directions, screen y grows downward
    typedef enum logic [1:0] {
        FACE_UP    = 2'd0,
        FACE_DOWN  = 2'd1,
        FACE_RIGHT = 2'd2,
        FACE_LEFT  = 2'd3
    } t_facing;

    // Far corner offsets from the apex and the far edge vector
    typedef struct packed {
        logic signed [OFF_BITS-1:0] e1x;
        logic signed [OFF_BITS-1:0] e1y;
        logic signed [OFF_BITS-1:0] e2x;
        logic signed [OFF_BITS-1:0] e2y;
        logic signed [OFF_BITS-1:0] d12x;
        logic signed [OFF_BITS-1:0] d12y;
    } t_offs;

    function automatic t_offs make_offs(
        input t_facing              facing,
        input logic [SPAN_BITS-1:0] reach,
        input logic [SPAN_BITS-1:0] half_width
    );
        t_offs                      o;
        logic signed [OFF_BITS-1:0] r;
        logic signed [OFF_BITS-1:0] hw;
        r  = $signed({2'b00, reach});
        hw = $signed({2'b00, half_width});
        unique case (facing)
            FACE_UP: begin
                o.e1x = -hw; o.e1y = -r;  o.e2x = hw;  o.e2y = -r;
            end
            FACE_DOWN: begin
                o.e1x = -hw; o.e1y = r;   o.e2x = hw;  o.e2y = r;
            end
            FACE_RIGHT: begin
                o.e1x = r;   o.e1y = -hw; o.e2x = r;   o.e2y = hw;
            end
            FACE_LEFT: begin
                o.e1x = -r;  o.e1y = -hw; o.e2x = -r;  o.e2y = hw;
            end
            default: begin
                o.e1x = '0;  o.e1y = '0;  o.e2x = '0;  o.e2y = '0;
            end
        endcase
        o.d12x = o.e1x - o.e2x;
        o.d12y = o.e1y - o.e2y;
        return o;
    endfunction

endpackage

/* hw/rtl/vcpt_core.sv */
`timescale 1ns / 1ps

module vcpt_core
    import vcpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [COORD_BITS-1:0] i_apex_x,
    input  logic signed [COORD_BITS-1:0] i_apex_y,
    input  t_offs                        i_offs,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_inside_res
);

    localparam int WD = ((COORD_BITS > SPAN_BITS) ? COORD_BITS : SPAN_BITS) + 2;
    localparam int WP = WD + OFF_BITS;
    localparam int WS = WP + 1;

    // Stage valids and load enables
    logic r_v1, r_v2, r_v3, r_vo;
    logic en1, en2, en3, eno;

    assign eno     = !r_vo || !i_stall;
    assign en3     = !r_v3 || eno;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_vo;

    // Stage 1: point relative to apex and to the second far corner
    logic signed [WD-1:0] n_u, n_v, n_du, n_dv;
    logic signed [WD-1:0] r_u, r_v, r_du, r_dv;

    assign n_u  = WD'(i_point_x) - WD'(i_apex_x);
    assign n_v  = WD'(i_point_y) - WD'(i_apex_y);
    assign n_du = n_u - WD'(i_offs.e2x);
    assign n_dv = n_v - WD'(i_offs.e2y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_u  <= n_u;
            r_v  <= n_v;
            r_du <= n_du;
            r_dv <= n_dv;
        end
    end

    // Stage 2: six partial cross products
    logic signed [WP-1:0] r_pa, r_pb, r_pc, r_pd, r_pe, r_pf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pa <= WP'(r_u) * WP'(i_offs.e2y);
            r_pb <= WP'(r_v) * WP'(i_offs.e2x);
            r_pc <= WP'(r_v) * WP'(i_offs.e1x);
            r_pd <= WP'(r_u) * WP'(i_offs.e1y);
            r_pe <= WP'(r_du) * WP'(i_offs.d12y);
            r_pf <= WP'(r_dv) * WP'(i_offs.d12x);
        end
    end

    // Stage 3: edge values, keep only their sign classes
    logic signed [WS-1:0] n_d1, n_d2, n_d3;
    logic [2:0]           r_neg, r_pos;

    assign n_d1 = WS'(r_pc) - WS'(r_pd);
    assign n_d2 = WS'(r_pe) - WS'(r_pf);
    assign n_d3 = WS'(r_pa) - WS'(r_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_neg <= {n_d3[WS-1], n_d2[WS-1], n_d1[WS-1]};
            r_pos <= {!n_d3[WS-1] && (n_d3 != '0),
                      !n_d2[WS-1] && (n_d2 != '0),
                      !n_d1[WS-1] && (n_d1 != '0)};
        end
    end

    // Output stage: inside unless signs mix
    logic r_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (eno) begin
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eno) begin
            r_inside <= !((|r_neg) && (|r_pos));
        end
    end

    assign o_inside_res = r_inside;

    // Checks
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_vo))
        else $error("input stalled while pipeline has a bubble");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted request did not enter stage 1");

    a_hold_products: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en2) |=> (r_v2 && $stable(r_pa) && $stable(r_pe)))
        else $error("stalled products changed");

    a_hold_signs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !en3) |=> (r_v3 && $stable(r_neg) && $stable(r_pos)))
        else $error("stalled edge signs changed");

endmodule

/* hw/rtl/view_cone_point_in_triangle_top.sv */
`timescale 1ns / 1ps

// View-cone point-in-triangle test. Configuration sets an apex, one of four
// axis facings, a reach and a half-width; each request carries one point and
// returns one flag that is 1 when the point lies inside the triangle or on
// its border (a degenerate triangle reports every point on its line). The
// pipeline takes one point per clock while o_stall is low; the flag passes
// through relative coordinates, a row of six signed multipliers, edge
// sign extraction, and the output register. Write configuration only while
// no request is in flight; writes take effect at once (ready is always high)
// and indexes above four are ignored. There is no clearing pass after reset.
module view_cone_point_in_triangle_top
    import vcpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int CFG_BITS  = (COORD_BITS > SPAN_BITS) ? COORD_BITS : SPAN_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [CFG_BITS-1:0]          i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_inside_res
);

    logic signed [COORD_BITS-1:0] r_apex_x, r_apex_y;
    t_facing                      r_facing;
    logic [SPAN_BITS-1:0]         r_reach, r_half_width;
    t_offs                        offs;

    assign o_cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apex_x     <= '0;
            r_apex_y     <= '0;
            r_facing     <= FACE_UP;
            r_reach      <= '0;
            r_half_width <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_APEX_X:     r_apex_x     <= i_cfg_data[COORD_BITS-1:0];
                CFG_APEX_Y:     r_apex_y     <= i_cfg_data[COORD_BITS-1:0];
                CFG_FACING:     r_facing     <= t_facing'(i_cfg_data[1:0]);
                CFG_REACH:      r_reach      <= i_cfg_data[SPAN_BITS-1:0];
                CFG_HALF_WIDTH: r_half_width <= i_cfg_data[SPAN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Corner offsets from the current configuration
    assign offs = make_offs(r_facing, r_reach, r_half_width);

    vcpt_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_apex_x     (r_apex_x),
        .i_apex_y     (r_apex_y),
        .i_offs       (offs),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_inside_res (o_inside_res)
    );

endmodule
